// File: hdl/grcm_pkg.sv
`default_nettype none
package grcm_pkg;

	// Channel count and memory geometry
	localparam int CHANNELS = 16;
	localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Field widths
	localparam int GAIN_W   = 40;
	localparam int VGAIN_W  = 24;
	localparam int LEN_W    = 12;
	localparam int SAMPLE_W = 24;
	localparam int DRY_W    = 32;
	localparam int THR_W    = 16;
	localparam int FRAC_SH  = 16;
	localparam int PROD_W   = SAMPLE_W + VGAIN_W;

	// Step divider: 41-bit magnitude, one quotient bit per cycle
	localparam int DIV_BITS = GAIN_W + 1;
	localparam int DIV_CW   = $clog2(DIV_BITS);

	// Item kinds
	localparam logic KIND_BEGIN  = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	// Per-channel state record held in the channel memory
	typedef struct packed {
		logic signed [GAIN_W-1:0]  gain;
		logic signed [GAIN_W-1:0]  step;
		logic signed [VGAIN_W-1:0] target;
		logic [LEN_W-1:0]          remaining;
	} grcm_entry_t;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_MUL  = 4'b0100,
		S_DIV  = 4'b1000
	} grcm_state_t;

endpackage
`default_nettype wire

// File: hdl/gain_ramp_channel_mixer.sv
// Sample item: channel memory read, then product, then saturation into the output
// register once it is free; the next item can be taken while that result loads.
// Begin item: S_READ only, or S_DIV after it when a ramp starts (41-step step divider).
// Reset clears the sequencer, the output valid and all channel valid bits, so
// every channel reads as zero gain, step, target and ramp; threshold resets to 1.
`default_nettype none
module gain_ramp_channel_mixer (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [grcm_pkg::THR_W-1:0]           cfg_wr_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic                                 kind,
	input  wire logic [3:0]                           channel,
	input  wire logic signed [grcm_pkg::VGAIN_W-1:0]  target_gain,
	input  wire logic [grcm_pkg::LEN_W-1:0]           ramp_length,
	input  wire logic signed [grcm_pkg::SAMPLE_W-1:0] sample_value,
	input  wire logic signed [grcm_pkg::DRY_W-1:0]    dry_in,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [grcm_pkg::DRY_W-1:0]         dry_out,
	output logic                                      saturated,
	output logic signed [grcm_pkg::VGAIN_W-1:0]       current_gain
);
	import grcm_pkg::*;

	grcm_state_t state_q;

	// Configuration and latched item
	logic [THR_W-1:0]           thr_q;
	logic                       kind_q;
	logic                       ch_ok_q;
	logic [CH_AW-1:0]           addr_q;
	logic signed [VGAIN_W-1:0]  target_q;
	logic [LEN_W-1:0]           len_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic signed [DRY_W-1:0]    dry_q;

	// Channel memory with per-entry valid bits
	grcm_entry_t                mem [CHANNELS];
	logic [CHANNELS-1:0]        valid_q;
	grcm_entry_t                rd_q;
	logic                       rd_valid_q;
	grcm_entry_t                entry;
	logic                       wr_en;
	grcm_entry_t                wr_data;

	// Multiply stage
	logic signed [PROD_W-1:0]   prod_s1;
	logic                       add_s1;
	logic signed [VGAIN_W-1:0]  gain_s1;

	// Divider
	logic [DIV_BITS-1:0]        dvd_q;
	logic [LEN_W:0]             rem_q;
	logic [DIV_CW-1:0]          cnt_q;
	logic                       neg_q;

	logic                       in_xfer;
	logic                       ch_ok;
	logic                       out_free;
	logic                       div_last;

	// Sample path signals
	logic signed [VGAIN_W-1:0]  g;
	logic [VGAIN_W-1:0]         mag;
	logic                       ramp;
	logic                       add;
	logic [LEN_W-1:0]           rem_n;
	logic signed [GAIN_W-1:0]   gain_n;
	logic signed [GAIN_W-1:0]   tfull;
	logic signed [GAIN_W:0]     diff;

	// Divider step signals
	logic [LEN_W:0]             shifted;
	logic                       qbit;
	logic [LEN_W:0]             rem_n_div;
	logic [DIV_BITS-1:0]        q_fin;
	logic [DIV_BITS-1:0]        q_sgn;

	// Output stage
	logic signed [DRY_W-1:0]    addend;
	logic signed [DRY_W:0]      sum;
	logic                       clip;
	logic signed [DRY_W-1:0]    sum_sat;

	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == S_IDLE) || ((state_q == S_MUL) && out_free);
	assign in_xfer  = in_valid && in_ready;
	assign ch_ok    = int'(channel) < CHANNELS;
	assign div_last = (cnt_q == DIV_CW'(DIV_BITS - 1));

	// Unwritten channels read as zero
	assign entry = rd_valid_q ? rd_q : '0;

	// Sample arithmetic on the fetched entry
	always_comb begin
		g      = entry.gain[GAIN_W-1:FRAC_SH];
		mag    = g[VGAIN_W-1] ? (~g + VGAIN_W'(1)) : g;
		ramp   = (entry.remaining != '0);
		add    = ch_ok_q && (ramp || (mag > VGAIN_W'(thr_q)));
		rem_n  = entry.remaining - LEN_W'(1);
		tfull  = {entry.target, {FRAC_SH{1'b0}}};
		if (!ramp) begin
			gain_n = entry.gain;
		end else if (rem_n == '0) begin
			gain_n = tfull;
		end else begin
			gain_n = entry.gain + entry.step;
		end
		diff = {target_q[VGAIN_W-1], target_q, {FRAC_SH{1'b0}}}
		       - {entry.gain[GAIN_W-1], entry.gain};
	end

	// One restoring division step
	always_comb begin
		shifted   = {rem_q[LEN_W-1:0], dvd_q[DIV_BITS-1]};
		qbit      = (shifted >= {1'b0, len_q});
		rem_n_div = qbit ? (shifted - {1'b0, len_q}) : shifted;
		q_fin     = {dvd_q[DIV_BITS-2:0], qbit};
		q_sgn     = neg_q ? (~q_fin + DIV_BITS'(1)) : q_fin;
	end

	// Select the write-back record
	always_comb begin
		wr_en   = 1'b0;
		wr_data = entry;
		case (state_q)
			S_READ: begin
				if (ch_ok_q) begin
					if (kind_q == KIND_SAMPLE) begin
						wr_en             = ramp;
						wr_data.gain      = gain_n;
						wr_data.remaining = rem_n;
					end else if ((diff == '0) || (len_q == '0)) begin
						wr_en             = 1'b1;
						wr_data.gain      = {target_q, {FRAC_SH{1'b0}}};
						wr_data.step      = '0;
						wr_data.target    = target_q;
						wr_data.remaining = '0;
					end
				end
			end
			S_DIV: begin
				if (div_last) begin
					wr_en             = 1'b1;
					wr_data.step      = q_sgn[GAIN_W-1:0];
					wr_data.target    = target_q;
					wr_data.remaining = len_q;
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Saturating accumulate
	always_comb begin
		addend = prod_s1[PROD_W-1:FRAC_SH];
		sum    = {dry_q[DRY_W-1], dry_q} + {addend[DRY_W-1], addend};
		clip   = add_s1 && (sum[DRY_W] != sum[DRY_W-1]);
		if (!add_s1) begin
			sum_sat = dry_q;
		end else if (clip) begin
			sum_sat = sum[DRY_W] ? {1'b1, {(DRY_W-1){1'b0}}} : {1'b0, {(DRY_W-1){1'b1}}};
		end else begin
			sum_sat = sum[DRY_W-1:0];
		end
	end

	// Channel memory: read on transfer, write back from the sequencer
	always_ff @(posedge clk) begin
		if (in_xfer && ch_ok) begin
			rd_q <= mem[CH_AW'(channel)];
		end
		if (wr_en) begin
			mem[addr_q] <= wr_data;
		end
	end

	// Valid bits and their registered read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				rd_valid_q <= ch_ok && valid_q[CH_AW'(channel)];
			end
			if (wr_en) begin
				valid_q[addr_q] <= 1'b1;
			end
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_W'(1);
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) state_q <= S_READ;
				end
				S_READ: begin
					if (kind_q == KIND_SAMPLE) begin
						state_q <= S_MUL;
					end else if (ch_ok_q && (diff != '0) && (len_q != '0)) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_MUL: begin
					if (in_xfer) begin
						state_q <= S_READ;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					if (div_last) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Latch the item on transfer
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_q   <= kind;
			ch_ok_q  <= ch_ok;
			addr_q   <= CH_AW'(channel);
			target_q <= target_gain;
			len_q    <= ramp_length;
			sample_q <= sample_value;
			dry_q    <= dry_in;
		end
	end

	// Multiply stage and visible gain after the update
	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			prod_s1 <= sample_q * g;
			add_s1  <= add;
			gain_s1 <= ch_ok_q ? gain_n[GAIN_W-1:FRAC_SH] : '0;
		end
	end

	// Divider: load magnitude of the gain difference, then shift in one bit a cycle
	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			dvd_q <= diff[GAIN_W] ? (~diff + DIV_BITS'(1)) : diff;
			neg_q <= diff[GAIN_W];
			rem_q <= '0;
			cnt_q <= '0;
		end else if (state_q == S_DIV) begin
			dvd_q <= q_fin;
			rem_q <= rem_n_div;
			cnt_q <= cnt_q + DIV_CW'(1);
		end
	end

	// Output register: hold until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if ((state_q == S_MUL) && out_free) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_MUL) && out_free) begin
			dry_out      <= sum_sat;
			saturated    <= clip;
			current_gain <= gain_s1;
		end
	end

endmodule
`default_nettype wire

// File: hdl/grcm_checker.sv
`default_nettype none
module grcm_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               kind,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic signed [31:0] dry_out,
	input wire logic               saturated,
	input wire logic signed [23:0] current_gain
);

	// Hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(dry_out) && $stable(saturated)
		&& $stable(current_gain))
		else $error("stalled result changed");

	// A clipped sum sits on a rail
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> (dry_out == 32'sh7fffffff) || (dry_out == 32'sh80000000))
		else $error("saturated flag without clipped value");

	// Every item is fetched before the next transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("transfer taken during channel read");

	// A sample transfer into an empty output is followed by a valid result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind && !out_valid |-> ##[1:3] out_valid)
		else $error("sample result missing");

endmodule

bind gain_ramp_channel_mixer grcm_checker u_grcm_checker (.*);
`default_nettype wire
